>>> sv/pf_pkg.sv
`timescale 1ns / 1ps
// Shared types and fixed constants for the prime factorizer.
// No dependencies; prime_factorizer_core imports it.

package pf_pkg;

    // Width of the number to factor and of every emitted factor
    localparam int NUM_W      = 24;
    // Quotient bits resolved per cycle by the trial divider
    localparam int DIV_BITS   = 4;
    localparam int DIV_CYCLES = NUM_W / DIV_BITS;
    localparam int DIV_CYC_W  = $clog2(DIV_CYCLES);

    typedef enum logic [3:0] {
        ST_CLR,      // clear composite marks
        ST_SV_RD,    // read mark of candidate
        ST_SV_CHK,   // record prime, start marking
        ST_SV_MARK,  // mark multiples
        ST_IDLE,
        ST_P_RD,     // read prime table entry
        ST_P_CHK,    // square bound check, load divider
        ST_DIV,      // trial division
        ST_DIV_END,  // inspect remainder
        ST_TAIL,     // emit leftover cofactor
        ST_FIN       // release final factor
    } state_t;

endpackage

>>> sv/prime_factorizer_core.sv
`timescale 1ns / 1ps
// Prime factorizer: sieve-built prime table plus trial division by table primes.
// Depends on pf_pkg (widths, divider constants, state type).
//
// Usage
//   Request channel: drive number and pulse start while busy is low; the request
//   is taken at that rising edge and busy rises the next cycle until the number
//   is fully factored.
//   Result channel: result_valid marks one factor per cycle on factor, last and
//   empty_res. Factors come in ascending order with repeats, then any leftover
//   cofactor above one; last is set on the final one. Zero or one gives a single
//   result with factor 0, last 1, empty_res 1, in the cycle after the request, and
//   busy stays low. At most MAX_FACTORS results are given per number.
//   The receiver cannot stall: every result is shown for exactly one cycle.
// Reset
//   After rst_n releases, busy stays high while the composite-mark memory is
//   cleared and the sieve fills the prime table (each candidate is read and
//   checked, then the multiples of each prime found are marked one by one).
// Processing
//   Per number: each table prime tried passes through table read, bound check,
//   the trial divider and a remainder check; each factor found repeats the
//   division on the quotient. The 4-bit-per-cycle trial divider dominates.

module prime_factorizer_core
    import pf_pkg::*;
#(
    parameter int SIEVE_LIMIT = 4096,
    parameter int MAX_FACTORS = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] number,
    output logic             busy,
    output logic             result_valid,
    output logic [NUM_W-1:0] factor,
    output logic             last,
    output logic             empty_res
);

    localparam int PW          = $clog2(SIEVE_LIMIT + 1);
    localparam int TABLE_DEPTH = SIEVE_LIMIT / 2 + 2;
    localparam int TW          = $clog2(TABLE_DEPTH);
    localparam int CW          = $clog2(MAX_FACTORS + 1);
    localparam int SQ_W        = (2 * PW > NUM_W) ? 2 * PW : NUM_W;

    // Composite marks and prime table memories
    logic          mark_mem [SIEVE_LIMIT + 1];
    logic [PW-1:0] table_mem [TABLE_DEPTH];

    logic          mk_we;
    logic [PW-1:0] mk_waddr;
    logic          mk_wdata;
    logic          mk_q;
    logic          tb_we;
    logic [PW-1:0] tb_q;

    // Control registers
    state_t        state_reg, state_next;
    logic [PW-1:0] clr_reg, clr_next;
    logic [PW-1:0] i_reg, i_next;
    logic [PW:0]   j_reg, j_next;
    logic [TW-1:0] count_reg, count_next;
    logic [TW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DIV_CYC_W-1:0] step_reg, step_next;
    logic          pend_valid_reg, pend_valid_next;
    logic          res_valid_reg, res_valid_next;

    // Data registers
    logic [NUM_W-1:0] n_reg, n_next;
    logic [NUM_W-1:0] remaining_reg, remaining_next;
    logic [PW-1:0]    p_reg, p_next;
    logic [NUM_W-1:0] qd_reg, qd_next;
    logic [PW-1:0]    part_reg, part_next;
    logic [NUM_W-1:0] pend_val_reg, pend_val_next;
    logic [NUM_W-1:0] factor_reg, factor_next;
    logic             last_reg, last_next;
    logic             empty_reg, empty_next;

    // Divider chunk outputs
    logic [PW-1:0]    div_part;
    logic [NUM_W-1:0] div_qd;

    logic             emit_req;
    logic [NUM_W-1:0] emit_val;
    logic             fin_req;
    logic             i_done;
    logic [PW:0]      j_sum;
    logic [PW:0]      j_first;
    logic [SQ_W-1:0]  p_sq;

    // Memories: one write and one registered read per cycle each
    always_ff @(posedge clk)
    begin
        if (mk_we)
        begin
            mark_mem[mk_waddr] <= mk_wdata;
        end
        mk_q <= mark_mem[i_reg];
    end

    always_ff @(posedge clk)
    begin
        if (tb_we)
        begin
            table_mem[count_reg] <= i_reg;
        end
        tb_q <= table_mem[idx_reg];
    end

    // Restoring division, DIV_BITS quotient bits per cycle
    always_comb
    begin : div_chunk
        logic [PW:0] trial;
        div_part = part_reg;
        div_qd   = qd_reg;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            trial  = {div_part, div_qd[NUM_W-1]};
            div_qd = {div_qd[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, p_reg})
            begin
                trial     = trial - {1'b0, p_reg};
                div_qd[0] = 1'b1;
            end
            div_part = trial[PW-1:0];
        end
    end

    assign i_done  = (i_reg == PW'(SIEVE_LIMIT));
    assign j_sum   = j_reg + {1'b0, i_reg};
    assign j_first = {i_reg, 1'b0};
    assign p_sq    = SQ_W'(tb_q) * SQ_W'(tb_q);

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        step_next       = step_reg;
        pend_valid_next = pend_valid_reg;
        res_valid_next  = 1'b0;
        n_next          = n_reg;
        remaining_next  = remaining_reg;
        p_next          = p_reg;
        qd_next         = qd_reg;
        part_next       = part_reg;
        pend_val_next   = pend_val_reg;
        factor_next     = factor_reg;
        last_next       = last_reg;
        empty_next      = empty_reg;
        mk_we           = 1'b0;
        mk_waddr        = clr_reg;
        mk_wdata        = 1'b0;
        tb_we           = 1'b0;
        emit_req        = 1'b0;
        emit_val        = remaining_reg;
        fin_req         = 1'b0;

        unique case (state_reg)
            ST_CLR:
            begin
                mk_we = 1'b1;
                if (clr_reg == PW'(SIEVE_LIMIT))
                begin
                    i_next     = PW'(2);
                    state_next = ST_SV_RD;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            ST_SV_RD:
            begin
                state_next = ST_SV_CHK;
            end

            ST_SV_CHK:
            begin
                if (!mk_q && j_first <= (PW + 1)'(SIEVE_LIMIT))
                begin
                    // prime with multiples inside the range: record and mark
                    tb_we      = 1'b1;
                    count_next = count_reg + 1'b1;
                    j_next     = j_first;
                    state_next = ST_SV_MARK;
                end
                else
                begin
                    if (!mk_q)
                    begin
                        tb_we      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (i_done)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_SV_RD;
                    end
                end
            end

            ST_SV_MARK:
            begin
                mk_we    = 1'b1;
                mk_waddr = j_reg[PW-1:0];
                mk_wdata = 1'b1;
                j_next   = j_sum;
                if (j_sum > (PW + 1)'(SIEVE_LIMIT))
                begin
                    if (i_done)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_SV_RD;
                    end
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    if (number < NUM_W'(2))
                    begin
                        // no factors: answer at once
                        res_valid_next = 1'b1;
                        factor_next    = '0;
                        last_next      = 1'b1;
                        empty_next     = 1'b1;
                    end
                    else
                    begin
                        n_next          = number;
                        remaining_next  = number;
                        idx_next        = '0;
                        cnt_next        = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_P_RD;
                    end
                end
            end

            ST_P_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    state_next = ST_TAIL;
                end
                else
                begin
                    state_next = ST_P_CHK;
                end
            end

            ST_P_CHK:
            begin
                if (p_sq > SQ_W'(n_reg) || remaining_reg == NUM_W'(1))
                begin
                    state_next = ST_TAIL;
                end
                else
                begin
                    p_next     = tb_q;
                    qd_next    = remaining_reg;
                    part_next  = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                part_next = div_part;
                qd_next   = div_qd;
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_CYC_W'(DIV_CYCLES - 1))
                begin
                    state_next = ST_DIV_END;
                end
            end

            ST_DIV_END:
            begin
                if (part_reg == '0)
                begin
                    // prime divides: emit it and retry on the quotient, or finish at MAX_FACTORS
                    emit_req       = 1'b1;
                    emit_val       = NUM_W'(p_reg);
                    remaining_next = qd_reg;
                    cnt_next       = cnt_reg + 1'b1;
                    if (cnt_reg == CW'(MAX_FACTORS - 1))
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        part_next  = '0;
                        step_next  = '0;
                        state_next = ST_DIV;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_P_RD;
                end
            end

            ST_TAIL:
            begin
                if (remaining_reg > NUM_W'(1))
                begin
                    emit_req = 1'b1;
                    emit_val = remaining_reg;
                end
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                fin_req    = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Hold one factor back so the final one can carry last
        if (emit_req)
        begin
            pend_val_next   = emit_val;
            pend_valid_next = 1'b1;
            if (pend_valid_reg)
            begin
                res_valid_next = 1'b1;
                factor_next    = pend_val_reg;
                last_next      = 1'b0;
                empty_next     = 1'b0;
            end
        end
        if (fin_req)
        begin
            res_valid_next  = pend_valid_reg;
            factor_next     = pend_val_reg;
            last_next       = 1'b1;
            empty_next      = 1'b0;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            clr_reg        <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            step_reg       <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            step_reg       <= step_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        remaining_reg <= remaining_next;
        p_reg         <= p_next;
        qd_reg        <= qd_next;
        part_reg      <= part_next;
        pend_val_reg  <= pend_val_next;
        factor_reg    <= factor_next;
        last_reg      <= last_next;
        empty_reg     <= empty_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign factor       = factor_reg;
    assign last         = last_reg;
    assign empty_res    = empty_reg;

endmodule
